// File: rtl/kvnl_pkg.sv
// Shared widths, constants and pipeline types of the vertex morph block.
package kvnl_pkg;

  localparam int ANGLE_STEPS_DEF = 256;

  localparam int COORD_W = 16;   // input coordinates
  localparam int PN_W    = 16;   // packed normal
  localparam int W_W     = 16;   // Q0.16 back weight
  localparam int POS_W   = 32;   // blended position
  localparam int NRM_W   = 16;   // Q1.14 normal component
  localparam int BLEND_W = 32;   // blended normal component before renormalize
  localparam int SUM_W   = 62;   // sum of squares of the blend
  localparam int ROOT_W  = 31;   // integer square root of that sum
  localparam int QUO_W   = 15;   // renormalized magnitude, 0..UNIT
  localparam int UNIT_SH = 14;

  localparam logic signed [NRM_W-1:0] UNIT_Q14 = 16'sd16384;

  typedef struct packed {
    logic                    vld;
    logic                    en;
  } pipe_ctl_t;

  // travels beside the normal math: blend enable, positions and the plain new normal
  typedef struct packed {
    logic                    blend_en;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_z;
  } side_t;

  typedef struct packed {
    logic signed [BLEND_W-1:0] x;
    logic signed [BLEND_W-1:0] y;
    logic signed [BLEND_W-1:0] z;
  } blend_t;

endpackage

// File: rtl/kvnl_if.sv
// Channel interfaces: vertex words in, result words out, weight writes.
interface kvnl_vtx_if import kvnl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] new_x;
  logic signed [COORD_W-1:0] new_y;
  logic signed [COORD_W-1:0] new_z;
  logic        [PN_W-1:0]    new_packed_normal;
  logic signed [COORD_W-1:0] old_x;
  logic signed [COORD_W-1:0] old_y;
  logic signed [COORD_W-1:0] old_z;
  logic        [PN_W-1:0]    old_packed_normal;

  modport source (output valid, new_x, new_y, new_z, new_packed_normal,
                  old_x, old_y, old_z, old_packed_normal, input ready);
  modport sink   (input valid, new_x, new_y, new_z, new_packed_normal,
                  old_x, old_y, old_z, old_packed_normal, output ready);
endinterface

interface kvnl_res_if import kvnl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [NRM_W-1:0] norm_x;
  logic signed [NRM_W-1:0] norm_y;
  logic signed [NRM_W-1:0] norm_z;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  output ready);
endinterface

interface kvnl_cfg_if import kvnl_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [W_W-1:0] back_weight;

  modport source (output valid, back_weight, input ready);
  modport sink   (input valid, back_weight, output ready);
endinterface

// File: rtl/kvnl_front.sv
// Front pipeline: normal decode, position and normal blend, sum of squares.
module kvnl_front import kvnl_pkg::*; #(
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pipe_ctl_t                 ctl,
  input  logic        [W_W-1:0]     back_weight,
  input  logic signed [COORD_W-1:0] new_c [3],
  input  logic signed [COORD_W-1:0] old_c [3],
  input  logic        [PN_W-1:0]    new_pn,
  input  logic        [PN_W-1:0]    old_pn,
  output logic                      vld,
  output side_t                     side,
  output blend_t                    blend,
  output logic        [SUM_W-1:0]   sum
);

  localparam int IDX_W  = $clog2(ANGLE_STEPS);
  localparam int PROD_W = 8 + $clog2(ANGLE_STEPS) + 1;
  localparam int PP_W   = COORD_W + W_W + 2;
  localparam int SQ_W   = 2 * BLEND_W;
  localparam int STAGES = 7;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'h4000_0000;

  typedef logic signed [NRM_W-1:0] trig_tbl_t [ANGLE_STEPS];

  // Taylor series in Q30, folded over quadrants; elaboration only
  function automatic logic signed [NRM_W-1:0] sin_phase(input logic [31:0] ph);
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    longint      acc;
    r = {34'd0, ph[29:0]};
    if (ph[30]) r = Q30_ONE - r;
    t    = (r * HALF_PI_Q30) >> 30;
    t2   = (t * t) >> 30;
    acc  = longint'(t);
    term = ((t * t2) >> 30) / 64'd6;      acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 64'd20;  acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 64'd42;  acc = acc - longint'(term);
    term = ((term * t2) >> 30) / 64'd72;  acc = acc + longint'(term);
    term = ((term * t2) >> 30) / 64'd110; acc = acc - longint'(term);
    if (acc < 0) acc = 0;
    acc = (acc + 64'sh8000) >>> 16;
    return ph[31] ? NRM_W'(-acc) : NRM_W'(acc);
  endfunction

  function automatic trig_tbl_t build_tbl(input logic quarter);
    trig_tbl_t   tb;
    logic [63:0] ph;
    for (int j = 0; j < ANGLE_STEPS; j++) begin
      ph    = (64'(j) << 32) / 64'(ANGLE_STEPS);
      tb[j] = sin_phase(32'(ph) + (quarter ? 32'h4000_0000 : 32'h0));
    end
    return tb;
  endfunction

  localparam trig_tbl_t SIN_TBL = build_tbl(1'b0);
  localparam trig_tbl_t COS_TBL = build_tbl(1'b1);

  function automatic logic [IDX_W-1:0] angle_idx(input logic [7:0] a);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(ANGLE_STEPS);
    return IDX_W'(p >> 8);
  endfunction

  function automatic logic signed [NRM_W-1:0] round_q14(input logic signed [31:0] p);
    logic signed [31:0] t;
    t = p + (32'sd1 <<< (UNIT_SH - 1));
    return NRM_W'(t >>> UNIT_SH);
  endfunction

  logic [STAGES-1:0] stg_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= '0;
    end else if (ctl.en) begin
      stg_vld <= {stg_vld[STAGES-2:0], ctl.vld};
    end
  end

  // index 0 is the new frame, 1 the old frame
  logic [PN_W-1:0] pn [2];
  assign pn[0] = new_pn;
  assign pn[1] = old_pn;

  // stage 1: table reads and coordinate differences
  logic signed [NRM_W-1:0]   s1_slat [2];
  logic signed [NRM_W-1:0]   s1_clat [2];
  logic signed [NRM_W-1:0]   s1_slon [2];
  logic signed [NRM_W-1:0]   s1_clon [2];
  logic signed [COORD_W-1:0] s1_n [3];
  logic signed [COORD_W:0]   s1_d [3];
  logic        [W_W-1:0]     s1_w;
  // stage 2: products
  logic signed [PP_W-1:0]    s2_pp [3];
  logic signed [COORD_W-1:0] s2_n [3];
  logic signed [31:0]        s2_xp [2];
  logic signed [31:0]        s2_yp [2];
  logic signed [NRM_W-1:0]   s2_zp [2];
  logic        [W_W-1:0]     s2_w;
  // stage 3: positions done, expanded normals
  logic signed [POS_W-1:0]   s3_pos [3];
  logic signed [NRM_W-1:0]   s3_nn [3];
  logic signed [NRM_W:0]     s3_dn [3];
  logic        [W_W-1:0]     s3_w;
  // stage 4: normal blend products
  logic signed [PP_W-1:0]    s4_bp [3];
  logic signed [POS_W-1:0]   s4_pos [3];
  logic signed [NRM_W-1:0]   s4_nn [3];
  logic                      s4_wnz;
  // stage 5: blended normal
  logic signed [BLEND_W-1:0] s5_b [3];
  logic signed [POS_W-1:0]   s5_pos [3];
  logic signed [NRM_W-1:0]   s5_nn [3];
  logic                      s5_wnz;
  // stage 6: squares
  logic        [SUM_W-1:0]   s6_sq [3];
  logic signed [BLEND_W-1:0] s6_b [3];
  logic signed [POS_W-1:0]   s6_pos [3];
  logic signed [NRM_W-1:0]   s6_nn [3];
  logic                      s6_wnz;
  // stage 7: sum
  logic        [SUM_W-1:0]   s7_sum;
  logic signed [BLEND_W-1:0] s7_b [3];
  logic signed [POS_W-1:0]   s7_pos [3];
  logic signed [NRM_W-1:0]   s7_nn [3];
  logic                      s7_wnz;

  logic signed [NRM_W-1:0] nrm3 [2][3];
  logic signed [POS_W-1:0] pos3 [3];
  logic signed [SQ_W-1:0]  sq6 [3];

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      nrm3[f][0] = round_q14(s2_xp[f]);
      nrm3[f][1] = round_q14(s2_yp[f]);
      nrm3[f][2] = s2_zp[f];
    end
    for (int c = 0; c < 3; c++) begin
      pos3[c] = POS_W'((PP_W'(s2_n[c]) <<< W_W) + s2_pp[c]);
      sq6[c]  = SQ_W'(s5_b[c]) * SQ_W'(s5_b[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int f = 0; f < 2; f++) begin
        s1_slat[f] <= SIN_TBL[angle_idx(pn[f][15:8])];
        s1_clat[f] <= COS_TBL[angle_idx(pn[f][15:8])];
        s1_slon[f] <= SIN_TBL[angle_idx(pn[f][7:0])];
        s1_clon[f] <= COS_TBL[angle_idx(pn[f][7:0])];
        s2_xp[f]   <= 32'(s1_clat[f]) * 32'(s1_slon[f]);
        s2_yp[f]   <= 32'(s1_slat[f]) * 32'(s1_slon[f]);
        s2_zp[f]   <= s1_clon[f];
      end
      s1_w <= back_weight;
      s2_w <= s1_w;
      s3_w <= s2_w;
      s4_wnz <= (s3_w != '0);
      s5_wnz <= s4_wnz;
      s6_wnz <= s5_wnz;
      s7_wnz <= s6_wnz;
      for (int c = 0; c < 3; c++) begin
        s1_n[c]   <= new_c[c];
        s1_d[c]   <= (COORD_W+1)'(old_c[c]) - (COORD_W+1)'(new_c[c]);
        s2_pp[c]  <= PP_W'(s1_d[c]) * PP_W'($signed({1'b0, s1_w}));
        s2_n[c]   <= s1_n[c];
        s3_pos[c] <= pos3[c];
        s3_nn[c]  <= nrm3[0][c];
        s3_dn[c]  <= (NRM_W+1)'(nrm3[1][c]) - (NRM_W+1)'(nrm3[0][c]);
        s4_bp[c]  <= PP_W'(s3_dn[c]) * PP_W'($signed({1'b0, s3_w}));
        s4_pos[c] <= s3_pos[c];
        s4_nn[c]  <= s3_nn[c];
        s5_b[c]   <= BLEND_W'((PP_W'(s4_nn[c]) <<< W_W) + s4_bp[c]);
        s5_pos[c] <= s4_pos[c];
        s5_nn[c]  <= s4_nn[c];
        s6_sq[c]  <= sq6[c][SUM_W-1:0];
        s6_b[c]   <= s5_b[c];
        s6_pos[c] <= s5_pos[c];
        s6_nn[c]  <= s5_nn[c];
        s7_b[c]   <= s6_b[c];
        s7_pos[c] <= s6_pos[c];
        s7_nn[c]  <= s6_nn[c];
      end
      s7_sum <= s6_sq[0] + s6_sq[1] + s6_sq[2];
    end
  end

  assign vld   = stg_vld[STAGES-1];
  assign sum   = s7_sum;
  assign side  = '{blend_en: s7_wnz, pos_x: s7_pos[0], pos_y: s7_pos[1],
                   pos_z: s7_pos[2], nrm_x: s7_nn[0], nrm_y: s7_nn[1],
                   nrm_z: s7_nn[2]};
  assign blend = '{x: s7_b[0], y: s7_b[1], z: s7_b[2]};

endmodule

// File: rtl/kvnl_isqrt.sv
// Integer square root, one result bit per pipeline stage.
module kvnl_isqrt import kvnl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctl_t         ctl,
  input  side_t             side_in,
  input  blend_t            blend_in,
  input  logic [SUM_W-1:0]  sum,
  output logic              vld,
  output side_t             side,
  output blend_t            blend,
  output logic [ROOT_W-1:0] root
);

  localparam int TRIAL_W = SUM_W + 2;

  logic [ROOT_W-1:0] stg_vld;
  logic [SUM_W-1:0]  rem [ROOT_W];
  logic [ROOT_W-1:0] acc [ROOT_W];
  side_t             stg_side [ROOT_W];
  blend_t            stg_blend [ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= '0;
    end else if (ctl.en) begin
      stg_vld <= {stg_vld[ROOT_W-2:0], ctl.vld};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int BIT = ROOT_W - 1 - k;
    logic [SUM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  acc_in;
    side_t              side_k;
    blend_t             blend_k;
    logic [TRIAL_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = sum;
      assign acc_in  = '0;
      assign side_k  = side_in;
      assign blend_k = blend_in;
    end else begin : g_rest
      assign rem_in  = rem[k-1];
      assign acc_in  = acc[k-1];
      assign side_k  = stg_side[k-1];
      assign blend_k = stg_blend[k-1];
    end

    // (r + 2^i)^2 - r^2
    assign trial = (TRIAL_W'(acc_in) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if (TRIAL_W'(rem_in) >= trial) begin
          rem[k] <= SUM_W'(TRIAL_W'(rem_in) - trial);
          acc[k] <= acc_in | (ROOT_W'(1) << BIT);
        end else begin
          rem[k] <= rem_in;
          acc[k] <= acc_in;
        end
        stg_side[k]  <= side_k;
        stg_blend[k] <= blend_k;
      end
    end
  end

  assign vld   = stg_vld[ROOT_W-1];
  assign root  = acc[ROOT_W-1];
  assign side  = stg_side[ROOT_W-1];
  assign blend = stg_blend[ROOT_W-1];

endmodule

// File: rtl/kvnl_div.sv
// Renormalize divider: three restoring lanes, one quotient bit per stage.
module kvnl_div import kvnl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctl_t               ctl,
  input  side_t                   side_in,
  input  blend_t                  blend_in,
  input  logic [ROOT_W-1:0]       root,
  output logic                    vld,
  output side_t                   side,
  output logic signed [NRM_W-1:0] nrm [3]
);

  localparam int NUM_W = ROOT_W + UNIT_SH + 2;
  localparam int DEN_W = ROOT_W + 1;

  logic [QUO_W:0]       stg_vld;
  logic [QUO_W:0]       use_b;
  logic [NUM_W-1:0]     num [QUO_W+1][3];
  logic [QUO_W-1:0]     quo [QUO_W+1][3];
  logic [2:0]           neg [QUO_W+1];
  logic [DEN_W-1:0]     den [QUO_W+1];
  side_t                stg_side [QUO_W+1];

  logic signed [BLEND_W-1:0] b_in [3];
  logic        [BLEND_W-1:0] mag [3];

  assign b_in[0] = blend_in.x;
  assign b_in[1] = blend_in.y;
  assign b_in[2] = blend_in.z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = b_in[c][BLEND_W-1] ? BLEND_W'(-b_in[c]) : BLEND_W'(b_in[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= '0;
    end else if (ctl.en) begin
      stg_vld <= {stg_vld[QUO_W-1:0], ctl.vld};
    end
  end

  // prep: round half away by dividing 2*|b|*UNIT + L by 2*L
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      den[0]      <= {root, 1'b0};
      use_b[0]    <= side_in.blend_en && (root != '0);
      stg_side[0] <= side_in;
      for (int c = 0; c < 3; c++) begin
        neg[0][c] <= b_in[c][BLEND_W-1];
        num[0][c] <= (NUM_W'(mag[c][ROOT_W-1:0]) << (UNIT_SH + 1)) + NUM_W'(root);
        quo[0][c] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - k;
    logic [NUM_W-1:0] dsh;
    assign dsh = NUM_W'(den[k-1]) << BIT;

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        for (int c = 0; c < 3; c++) begin
          if (num[k-1][c] >= dsh) begin
            num[k][c] <= num[k-1][c] - dsh;
            quo[k][c] <= quo[k-1][c] | (QUO_W'(1) << BIT);
          end else begin
            num[k][c] <= num[k-1][c];
            quo[k][c] <= quo[k-1][c];
          end
        end
        den[k]      <= den[k-1];
        use_b[k]    <= use_b[k-1];
        neg[k]      <= neg[k-1];
        stg_side[k] <= stg_side[k-1];
      end
    end
  end

  logic signed [NRM_W-1:0] plain [3];
  logic        [QUO_W-1:0] qs [3];

  assign plain[0] = stg_side[QUO_W].nrm_x;
  assign plain[1] = stg_side[QUO_W].nrm_y;
  assign plain[2] = stg_side[QUO_W].nrm_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qs[c] = (quo[QUO_W][c] > QUO_W'(UNIT_Q14)) ? QUO_W'(UNIT_Q14) : quo[QUO_W][c];
      if (use_b[QUO_W]) begin
        nrm[c] = neg[QUO_W][c] ? -NRM_W'(qs[c]) : NRM_W'(qs[c]);
      end else begin
        nrm[c] = plain[c];
      end
    end
  end

  assign vld  = stg_vld[QUO_W];
  assign side = stg_side[QUO_W];

  // |b| never exceeds floor(sqrt(sum)), so the quotient stays within unit
  a_quo_unit: assert property (@(posedge clk) disable iff (rst)
    stg_vld[QUO_W] && use_b[QUO_W] |->
      quo[QUO_W][0] <= QUO_W'(UNIT_Q14) && quo[QUO_W][1] <= QUO_W'(UNIT_Q14) &&
      quo[QUO_W][2] <= QUO_W'(UNIT_Q14))
    else $error("renormalize quotient above unit");

endmodule

// File: rtl/keyframe_vertex_normal_lerp.sv
// Top level of the keyframe vertex morph with normal renormalize.
//
// Channels: vertex (sink) takes one word per vertex with old and new frame
// coordinates and packed normals; result (source) gives the blended position
// and unit normal; cfg (sink) writes the Q0.16 back weight and is always
// ready. A word moves on a clock edge with valid and ready both high.
// A vertex word passes through 7 front stages, 31 square root stages,
// 16 divider stages and 1 output register. Throughput: one vertex per
// clock while the pipeline advances; every stage is a register and the
// square root and divider resolve one bit per stage.
// The whole pipeline advances together while the output register is empty
// or being read; when the receiver holds result.ready low with a word
// waiting, the pipeline and vertex.ready hold and nothing is lost.
// Reset (rst, synchronous) clears every valid bit and sets the weight to 0;
// with weight 0 positions are new * 65536 and the new normal passes through.
// Change the weight only while no vertex is in flight.
module keyframe_vertex_normal_lerp import kvnl_pkg::*; #(
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input logic        clk,
  input logic        rst,
  kvnl_vtx_if.sink   vertex,
  kvnl_res_if.source result,
  kvnl_cfg_if.sink   cfg
);

  logic [W_W-1:0] back_weight;
  logic           en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      back_weight <= '0;
    end else if (cfg.valid && cfg.ready) begin
      back_weight <= cfg.back_weight;
    end
  end

  assign en           = !result.valid || result.ready;
  assign vertex.ready = en;

  logic signed [COORD_W-1:0] new_c [3];
  logic signed [COORD_W-1:0] old_c [3];

  assign new_c[0] = vertex.new_x;
  assign new_c[1] = vertex.new_y;
  assign new_c[2] = vertex.new_z;
  assign old_c[0] = vertex.old_x;
  assign old_c[1] = vertex.old_y;
  assign old_c[2] = vertex.old_z;

  pipe_ctl_t         f_ctl;
  pipe_ctl_t         q_ctl;
  pipe_ctl_t         d_ctl;
  logic              f_vld;
  side_t             f_side;
  blend_t            f_blend;
  logic [SUM_W-1:0]  f_sum;
  logic              q_vld;
  side_t             q_side;
  blend_t            q_blend;
  logic [ROOT_W-1:0] q_root;
  logic              d_vld;
  side_t             d_side;
  logic signed [NRM_W-1:0] d_nrm [3];

  assign f_ctl = '{vld: vertex.valid, en: en};
  assign q_ctl = '{vld: f_vld, en: en};
  assign d_ctl = '{vld: q_vld, en: en};

  kvnl_front #(.ANGLE_STEPS(ANGLE_STEPS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .ctl         (f_ctl),
    .back_weight (back_weight),
    .new_c       (new_c),
    .old_c       (old_c),
    .new_pn      (vertex.new_packed_normal),
    .old_pn      (vertex.old_packed_normal),
    .vld         (f_vld),
    .side        (f_side),
    .blend       (f_blend),
    .sum         (f_sum)
  );

  kvnl_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl      (q_ctl),
    .side_in  (f_side),
    .blend_in (f_blend),
    .sum      (f_sum),
    .vld      (q_vld),
    .side     (q_side),
    .blend    (q_blend),
    .root     (q_root)
  );

  kvnl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (d_ctl),
    .side_in  (q_side),
    .blend_in (q_blend),
    .root     (q_root),
    .vld      (d_vld),
    .side     (d_side),
    .nrm      (d_nrm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.pos_x  <= d_side.pos_x;
      result.pos_y  <= d_side.pos_y;
      result.pos_z  <= d_side.pos_z;
      result.norm_x <= d_nrm[0];
      result.norm_y <= d_nrm[1];
      result.norm_z <= d_nrm[2];
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      result.norm_x >= -UNIT_Q14 && result.norm_x <= UNIT_Q14 &&
      result.norm_y >= -UNIT_Q14 && result.norm_y <= UNIT_Q14 &&
      result.norm_z >= -UNIT_Q14 && result.norm_z <= UNIT_Q14)
    else $error("normal component outside unit range");

  a_load_on_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(en))
    else $error("result valid rose while pipeline stalled");

endmodule
